### rtl/hbb_pkg.sv
// ----------------------------------------------------------------------------
// hbb_pkg
// Shared widths, constants and types of the projective bounding box pipeline.
// ----------------------------------------------------------------------------
package hbb_pkg;

   // largest accepted source dimension
   localparam int MAX_DIM   = 8192;
   localparam int DIM_IN_W  = 14;
   localparam int COEF_W    = 48;
   // width of a corner coordinate (dimension minus one)
   localparam int CRD_W     = $clog2(MAX_DIM);
   localparam int PROD_W    = COEF_W + CRD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   // rounding divider operands: 2|n|+|d| and 2|d|
   localparam int NUM_W     = SUM_W + 2;
   localparam int DEN_W     = SUM_W + 1;
   localparam int QBITS     = 22;
   localparam int CMP_W     = NUM_W + QBITS;
   localparam int PIX_W     = 22;
   localparam int COORD_LIM = 1048576;
   // divider depth in stages: prepare, range check, one stage per quotient bit, finish
   localparam int DIV_LAT   = QBITS + 3;
   localparam int SIZE_W    = 16;
   localparam int SZ_W      = PIX_W + 1;
   localparam int FRAC_W    = 32;
   localparam int SHF_W     = PIX_W + FRAC_W + 2;
   localparam int NCOEF     = 9;
   localparam int NCORNER   = 4;

   // coefficient slots in input order
   localparam int C_XX = 0;
   localparam int C_XY = 1;
   localparam int C_XC = 2;
   localparam int C_YX = 3;
   localparam int C_YY = 4;
   localparam int C_YC = 5;
   localparam int C_WX = 6;
   localparam int C_WY = 7;
   localparam int C_WC = 8;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [PIX_W-1:0]  pix_type;

   // mapped homogeneous corner
   typedef struct packed {
      sum_type nx;
      sum_type ny;
      sum_type nw;
   } corner_type;

   // sign and range flags that travel through the divider
   typedef struct packed {
      logic nneg;
      logic qneg;
      logic dzero;
      logic ovf;
   } div_ctl_type;

endpackage

### rtl/hbb_corner.sv
// ----------------------------------------------------------------------------
// hbb_corner
// Clamps the image size, forms the six coordinate products and sums the
// three transform rows at the four image corners. Three register stages.
// ----------------------------------------------------------------------------
module hbb_corner import hbb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [DIM_IN_W-1:0] image_width,
   input  logic [DIM_IN_W-1:0] image_height,
   input  coef_type            coef [NCOEF],
   output logic                out_valid,
   output corner_type          corner [NCORNER],
   output coef_type            out_xc,
   output coef_type            out_yc,
   output logic                out_fault
);

   logic                v1_ff, v2_ff, v3_ff;
   logic [CRD_W-1:0]    wm1_ff, wm1_in, hm1_ff, hm1_in;
   coef_type            coef_ff [NCOEF];
   logic                flt1_ff, flt1_in, flt2_ff, flt3_ff;
   logic signed [PROD_W-1:0] prod_ff [6];
   logic signed [PROD_W-1:0] prod_in [6];
   coef_type            c2_ff [3];
   coef_type            xc3_ff, yc3_ff;
   corner_type          corner_ff [NCORNER];
   corner_type          corner_in [NCORNER];
   logic                wz, wbig, hz, hbig;

   // clamp the dimensions and take dimension minus one
   always_comb begin
      wz      = (image_width == '0);
      hz      = (image_height == '0);
      wbig    = ({18'd0, image_width} > 32'(MAX_DIM));
      hbig    = ({18'd0, image_height} > 32'(MAX_DIM));
      wm1_in  = wz ? '0 : (wbig ? CRD_W'(MAX_DIM - 1) : CRD_W'(image_width - 1'b1));
      hm1_in  = hz ? '0 : (hbig ? CRD_W'(MAX_DIM - 1) : CRD_W'(image_height - 1'b1));
      flt1_in = wz | hz | wbig | hbig;
   end

   // coefficient times far corner coordinate
   always_comb begin
      prod_in[0] = PROD_W'(coef_ff[C_XX]) * PROD_W'($signed({1'b0, wm1_ff}));
      prod_in[1] = PROD_W'(coef_ff[C_XY]) * PROD_W'($signed({1'b0, hm1_ff}));
      prod_in[2] = PROD_W'(coef_ff[C_YX]) * PROD_W'($signed({1'b0, wm1_ff}));
      prod_in[3] = PROD_W'(coef_ff[C_YY]) * PROD_W'($signed({1'b0, hm1_ff}));
      prod_in[4] = PROD_W'(coef_ff[C_WX]) * PROD_W'($signed({1'b0, wm1_ff}));
      prod_in[5] = PROD_W'(coef_ff[C_WY]) * PROD_W'($signed({1'b0, hm1_ff}));
   end

   // sum each row at the four corners
   always_comb begin
      for (int k = 0; k < NCORNER; k++) begin
         corner_in[k].nx = SUM_W'(c2_ff[0])
                         + ((k % 2 == 1) ? SUM_W'(prod_ff[0]) : '0)
                         + ((k / 2 == 1) ? SUM_W'(prod_ff[1]) : '0);
         corner_in[k].ny = SUM_W'(c2_ff[1])
                         + ((k % 2 == 1) ? SUM_W'(prod_ff[2]) : '0)
                         + ((k / 2 == 1) ? SUM_W'(prod_ff[3]) : '0);
         corner_in[k].nw = SUM_W'(c2_ff[2])
                         + ((k % 2 == 1) ? SUM_W'(prod_ff[4]) : '0)
                         + ((k / 2 == 1) ? SUM_W'(prod_ff[5]) : '0);
      end
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (en) begin
         wm1_ff  <= wm1_in;
         hm1_ff  <= hm1_in;
         coef_ff <= coef;
         flt1_ff <= flt1_in;
         prod_ff <= prod_in;
         c2_ff[0] <= coef_ff[C_XC];
         c2_ff[1] <= coef_ff[C_YC];
         c2_ff[2] <= coef_ff[C_WC];
         flt2_ff <= flt1_ff;
         corner_ff <= corner_in;
         xc3_ff  <= c2_ff[0];
         yc3_ff  <= c2_ff[1];
         flt3_ff <= flt2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign corner    = corner_ff;
   assign out_xc    = xc3_ff;
   assign out_yc    = yc3_ff;
   assign out_fault = flt3_ff;

endmodule

### rtl/hbb_div.sv
// ----------------------------------------------------------------------------
// hbb_div
// Pipelined rounding divider: round(n/d) half away from zero, clamped to
// the coordinate limit, one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module hbb_div import hbb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  sum_type num,
   input  sum_type den,
   output logic    out_valid,
   output pix_type coord,
   output logic    zdiv
);

   logic [SUM_W-1:0] nabs, dabs;
   logic [NUM_W-1:0] numa_ff, numa_in;
   logic [DEN_W-1:0] dena_ff, dena_in;
   div_ctl_type      ctla_ff, ctla_in;
   div_ctl_type      ctl0_in;
   logic             va_ff;

   logic [NUM_W-1:0] rem_ff [QBITS+1];
   logic [DEN_W-1:0] den_ff [QBITS+1];
   logic [QBITS-1:0] q_ff   [QBITS+1];
   div_ctl_type      ctl_ff [QBITS+1];
   logic             v_ff   [QBITS+1];

   pix_type          coord_ff, coord_in;
   logic             zdiv_ff, vo_ff;
   logic [QBITS-1:0] qv;
   pix_type          mag;

   // magnitudes and rounding offset
   always_comb begin
      nabs          = num[SUM_W-1] ? (~num + 1'b1) : num;
      dabs          = den[SUM_W-1] ? (~den + 1'b1) : den;
      numa_in       = {1'b0, nabs, 1'b0} + NUM_W'(dabs);
      dena_in       = {dabs, 1'b0};
      ctla_in.nneg  = num[SUM_W-1];
      ctla_in.qneg  = num[SUM_W-1] ^ den[SUM_W-1];
      ctla_in.dzero = (den == '0);
      ctla_in.ovf   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numa_ff <= numa_in;
         dena_ff <= dena_in;
         ctla_ff <= ctla_in;
      end
   end

   // flag a quotient that does not fit the bit stages
   always_comb begin
      ctl0_in     = ctla_ff;
      ctl0_in.ovf = ({{QBITS{1'b0}}, numa_ff} >= {1'b0, dena_ff, {QBITS{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= numa_ff;
         den_ff[0] <= dena_ff;
         q_ff[0]   <= '0;
         ctl_ff[0] <= ctl0_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QBITS; k++) begin : g_bit
      logic [CMP_W-1:0] remx, dsh, diff;
      logic             ge;

      always_comb begin
         remx = {{QBITS{1'b0}}, rem_ff[k]};
         dsh  = {{(CMP_W-DEN_W){1'b0}}, den_ff[k]} << (QBITS - 1 - k);
         diff = remx - dsh;
         ge   = (remx >= dsh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[NUM_W-1:0] : rem_ff[k];
            den_ff[k+1] <= den_ff[k];
            q_ff[k+1]   <= {q_ff[k][QBITS-2:0], ge};
            ctl_ff[k+1] <= ctl_ff[k];
         end
      end
   end

   // clamp, apply sign, saturate a zero divisor
   always_comb begin
      qv  = q_ff[QBITS];
      mag = (ctl_ff[QBITS].ovf || (qv > QBITS'(COORD_LIM))) ? PIX_W'(COORD_LIM)
                                                            : PIX_W'(qv);
      if (ctl_ff[QBITS].dzero) begin
         coord_in = ctl_ff[QBITS].nneg ? -PIX_W'(COORD_LIM) : PIX_W'(COORD_LIM);
      end else begin
         coord_in = ctl_ff[QBITS].qneg ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= coord_in;
         zdiv_ff  <= ctl_ff[QBITS].dzero;
      end
   end

   assign out_valid = vo_ff;
   assign coord     = coord_ff;
   assign zdiv      = zdiv_ff;

endmodule

### rtl/hbb_box.sv
// ----------------------------------------------------------------------------
// hbb_box
// Takes minimum and maximum over the four projected corners, then forms the
// saturated box size and the shifted translation terms. Two stages.
// ----------------------------------------------------------------------------
module hbb_box import hbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  pix_type           px [NCORNER],
   input  pix_type           py [NCORNER],
   input  coef_type          xc,
   input  coef_type          yc,
   input  logic              fault_in,
   output logic              out_valid,
   output logic [SIZE_W-1:0] out_width,
   output logic [SIZE_W-1:0] out_height,
   output coef_type          new_xcoef_c,
   output coef_type          new_ycoef_c,
   output logic              fault
);

   logic     va_ff, vb_ff;
   pix_type  minx_ff, maxx_ff, miny_ff, maxy_ff;
   pix_type  minx_in, maxx_in, miny_in, maxy_in;
   coef_type xca_ff, yca_ff;
   logic     flta_ff;

   logic [SIZE_W-1:0] w_ff, h_ff, w_in, h_in;
   coef_type          nxc_ff, nyc_ff, nxc_in, nyc_in;
   logic              fltb_ff, fltb_in;

   function automatic pix_type pmin(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type pmax(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   // reduce the four corners
   always_comb begin
      minx_in = pmin(pmin(px[0], px[1]), pmin(px[2], px[3]));
      maxx_in = pmax(pmax(px[0], px[1]), pmax(px[2], px[3]));
      miny_in = pmin(pmin(py[0], py[1]), pmin(py[2], py[3]));
      maxy_in = pmax(pmax(py[0], py[1]), pmax(py[2], py[3]));
   end

   // saturate sizes and shifted translations
   always_comb begin
      logic signed [SZ_W-1:0]  sw, sh;
      logic signed [SHF_W-1:0] rx, ry;
      logic                    sx_sat, sy_sat, tx_sat, ty_sat;
      sw = SZ_W'(maxx_ff) - SZ_W'(minx_ff) + SZ_W'(1);
      sh = SZ_W'(maxy_ff) - SZ_W'(miny_ff) + SZ_W'(1);
      sx_sat = (sw[SZ_W-1:SIZE_W] != '0);
      sy_sat = (sh[SZ_W-1:SIZE_W] != '0);
      w_in = sx_sat ? '1 : sw[SIZE_W-1:0];
      h_in = sy_sat ? '1 : sh[SIZE_W-1:0];
      rx = SHF_W'(xca_ff) - (SHF_W'(minx_ff) <<< FRAC_W);
      ry = SHF_W'(yca_ff) - (SHF_W'(miny_ff) <<< FRAC_W);
      tx_sat = (rx[SHF_W-1:COEF_W-1] != '0) && (rx[SHF_W-1:COEF_W-1] != '1);
      ty_sat = (ry[SHF_W-1:COEF_W-1] != '0) && (ry[SHF_W-1:COEF_W-1] != '1);
      nxc_in = tx_sat ? {rx[SHF_W-1], {(COEF_W-1){~rx[SHF_W-1]}}} : rx[COEF_W-1:0];
      nyc_in = ty_sat ? {ry[SHF_W-1], {(COEF_W-1){~ry[SHF_W-1]}}} : ry[COEF_W-1:0];
      fltb_in = flta_ff | sx_sat | sy_sat | tx_sat | ty_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         minx_ff <= minx_in;
         maxx_ff <= maxx_in;
         miny_ff <= miny_in;
         maxy_ff <= maxy_in;
         xca_ff  <= xc;
         yca_ff  <= yc;
         flta_ff <= fault_in;
         w_ff    <= w_in;
         h_ff    <= h_in;
         nxc_ff  <= nxc_in;
         nyc_ff  <= nyc_in;
         fltb_ff <= fltb_in;
      end
   end

   assign out_valid   = vb_ff;
   assign out_width   = w_ff;
   assign out_height  = h_ff;
   assign new_xcoef_c = nxc_ff;
   assign new_ycoef_c = nyc_ff;
   assign fault       = fltb_ff;

endmodule

### rtl/homography_bounding_box.sv
// Pipeline: 3 corner stages, 25 divider stages and 2 box stages lie between
// an accepted request item and its response item.
// Throughput: one item per cycle; the whole pipeline holds while a response
// waits, and the 22 one-bit divider stages make up most of the depth.
// Reset: synchronous, active high; clears all valid bits, no other state.
// ----------------------------------------------------------------------------
// homography_bounding_box
// Maps the four image corners through a projective transform and returns
// the bounding box size and the translation that moves it to the origin.
// ----------------------------------------------------------------------------
module homography_bounding_box import hbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // image_width[13:0], image_height[27:14], xcoef_x, xcoef_y, xcoef_c,
   // ycoef_x, ycoef_y, ycoef_c, wcoef_x, wcoef_y, wcoef_c (48 each), zero pad
   input  logic [463:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_width[15:0], out_height[31:16], new_xcoef_c[79:32], new_ycoef_c[127:80]
   output logic [127:0] rsp_tdata,
   // fault[0]
   output logic [0:0]   rsp_tuser
);

   logic       en;
   coef_type   coef [NCOEF];
   logic       cv;
   corner_type corner [NCORNER];
   coef_type   cxc, cyc;
   logic       cflt;

   logic       dv [2*NCORNER];
   pix_type    dcoord [2*NCORNER];
   logic       dz [2*NCORNER];
   pix_type    px [NCORNER];
   pix_type    py [NCORNER];

   coef_type   dly_xc_ff [DIV_LAT];
   coef_type   dly_yc_ff [DIV_LAT];
   logic       dly_f_ff  [DIV_LAT];
   logic       box_fault;

   logic [SIZE_W-1:0] ow, oh;
   coef_type   nxc, nyc;
   logic       ofault;

   // hold every stage while a response waits
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   for (genvar i = 0; i < NCOEF; i++) begin : g_coef
      assign coef[i] = req_tdata[2*DIM_IN_W + COEF_W*i +: COEF_W];
   end

   hbb_corner u_corner (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_tvalid),
      .image_width  (req_tdata[DIM_IN_W-1:0]),
      .image_height (req_tdata[2*DIM_IN_W-1:DIM_IN_W]),
      .coef         (coef),
      .out_valid    (cv),
      .corner       (corner),
      .out_xc       (cxc),
      .out_yc       (cyc),
      .out_fault    (cflt)
   );

   // one divider for each coordinate of each corner
   for (genvar k = 0; k < NCORNER; k++) begin : g_div
      hbb_div u_div_x (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv),
         .num       (corner[k].nx),
         .den       (corner[k].nw),
         .out_valid (dv[2*k]),
         .coord     (dcoord[2*k]),
         .zdiv      (dz[2*k])
      );
      hbb_div u_div_y (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv),
         .num       (corner[k].ny),
         .den       (corner[k].nw),
         .out_valid (dv[2*k+1]),
         .coord     (dcoord[2*k+1]),
         .zdiv      (dz[2*k+1])
      );
      assign px[k] = dcoord[2*k];
      assign py[k] = dcoord[2*k+1];
   end

   // carry the translations and the early fault alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         dly_xc_ff[0] <= cxc;
         dly_yc_ff[0] <= cyc;
         dly_f_ff[0]  <= cflt;
         for (int i = 1; i < DIV_LAT; i++) begin
            dly_xc_ff[i] <= dly_xc_ff[i-1];
            dly_yc_ff[i] <= dly_yc_ff[i-1];
            dly_f_ff[i]  <= dly_f_ff[i-1];
         end
      end
   end

   always_comb begin
      box_fault = dly_f_ff[DIV_LAT-1];
      for (int i = 0; i < 2*NCORNER; i++) begin
         box_fault = box_fault | dz[i];
      end
   end

   hbb_box u_box (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (dv[0]),
      .px          (px),
      .py          (py),
      .xc          (dly_xc_ff[DIV_LAT-1]),
      .yc          (dly_yc_ff[DIV_LAT-1]),
      .fault_in    (box_fault),
      .out_valid   (rsp_tvalid),
      .out_width   (ow),
      .out_height  (oh),
      .new_xcoef_c (nxc),
      .new_ycoef_c (nyc),
      .fault       (ofault)
   );

   assign rsp_tdata = {nyc, nxc, oh, ow};
   assign rsp_tuser = ofault;

endmodule

### rtl/hbb_checker.sv
// ----------------------------------------------------------------------------
// hbb_checker
// Port-level checks of the bounding box pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module hbb_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [463:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response item changed while stalled");

   // the pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // requests stall only behind a waiting response
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without back pressure");

   // a box always covers at least one pixel each way
   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] != 16'd0 && rsp_tdata[31:16] != 16'd0)
      else $error("empty box size");

endmodule

bind homography_bounding_box hbb_checker u_hbb_checker (.*);

### tb/sv/homography_bounding_box_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_bounding_box_checker
// Watches the request and response streams of the bounding box block, works
// out the expected box for every accepted request item and compares each
// response item field by field with the oldest expected box.
// ----------------------------------------------------------------------------
module homography_bounding_box_checker import hbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [463:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   output int           error_count,
   output int           boxes_pending,
   output int           boxes_checked,
   output int           faults_seen
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [15:0]       width;
      logic [15:0]       height;
      logic [COEF_W-1:0] xshift;
      logic [COEF_W-1:0] yshift;
      logic              fault;
   } box_type;

   box_type expected_boxes[$];

   // Round n/d half away from zero, clamp to the coordinate limit.
   function automatic longint project_coord(wide_type n, wide_type dv, ref bit flt);
      logic [127:0] an, ad, q;
      longint       m;
      an = (n < 0) ? -n : n;
      ad = (dv < 0) ? -dv : dv;
      if (ad == 0) begin
         flt = 1'b1;
         return (n < 0) ? -longint'(COORD_LIM) : longint'(COORD_LIM);
      end
      q = (2 * an + ad) / (2 * ad);
      m = (q > COORD_LIM) ? longint'(COORD_LIM) : longint'(q[63:0]);
      return ((n < 0) != (dv < 0)) ? -m : m;
   endfunction

   function automatic logic [15:0] box_extent(longint lo, longint hi, ref bit flt);
      longint s;
      s = hi - lo + 1;
      if (s > 65535) begin
         flt = 1'b1;
         return 16'hFFFF;
      end
      return s[15:0];
   endfunction

   function automatic logic [COEF_W-1:0] shift_term(wide_type c, longint mn, ref bit flt);
      longint r;
      longint smax;
      smax = (longint'(1) <<< (COEF_W - 1)) - 1;
      r = longint'(c[63:0]) - mn * 64'sd4294967296;
      if (r > smax) begin
         flt = 1'b1;
         r = smax;
      end
      if (r < -smax - 1) begin
         flt = 1'b1;
         r = -smax - 1;
      end
      return r[COEF_W-1:0];
   endfunction

   function automatic box_type predict_box(logic [463:0] d);
      wide_type               c[NCOEF];
      logic signed [COEF_W-1:0] raw;
      longint                 dim[2];
      wide_type               x, y, nx, ny, nw;
      longint                 px, py, min_x, max_x, min_y, max_y;
      bit                     flt;
      box_type                b;
      flt = 1'b0;
      min_x = 0; max_x = 0; min_y = 0; max_y = 0;
      for (int i = 0; i < NCOEF; i++) begin
         raw = d[28 + COEF_W * i +: COEF_W];
         c[i] = raw;
      end
      // clamp out-of-range image sizes
      for (int j = 0; j < 2; j++) begin
         dim[j] = d[14 * j +: 14];
         if (dim[j] == 0) begin
            flt = 1'b1;
            dim[j] = 1;
         end else if (dim[j] > MAX_DIM) begin
            flt = 1'b1;
            dim[j] = MAX_DIM;
         end
      end
      // map the four corners and track the box
      for (int k = 0; k < NCORNER; k++) begin
         x = (k & 1) ? dim[0] - 1 : 0;
         y = (k >> 1) ? dim[1] - 1 : 0;
         nx = c[C_XX] * x + c[C_XY] * y + c[C_XC];
         ny = c[C_YX] * x + c[C_YY] * y + c[C_YC];
         nw = c[C_WX] * x + c[C_WY] * y + c[C_WC];
         px = project_coord(nx, nw, flt);
         py = project_coord(ny, nw, flt);
         if (k == 0 || px < min_x) min_x = px;
         if (k == 0 || px > max_x) max_x = px;
         if (k == 0 || py < min_y) min_y = py;
         if (k == 0 || py > max_y) max_y = py;
      end
      b.width  = box_extent(min_x, max_x, flt);
      b.height = box_extent(min_y, max_y, flt);
      b.xshift = shift_term(c[C_XC], min_x, flt);
      b.yshift = shift_term(c[C_YC], min_y, flt);
      b.fault  = flt;
      return b;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      error_count   = 0;
      boxes_checked = 0;
      faults_seen   = 0;
   end

   assign boxes_pending = expected_boxes.size();

   // Queue an expected box per accepted request, check each response item.
   always @(posedge clock) begin
      box_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_boxes.push_back(predict_box(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_boxes.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[63:0], 64'd0);
            end else begin
               want = expected_boxes.pop_front();
               boxes_checked++;
               if (want.fault) faults_seen++;
               if (rsp_tdata[15:0] !== want.width)
                  report_mismatch("out_width", rsp_tdata[15:0], want.width);
               if (rsp_tdata[31:16] !== want.height)
                  report_mismatch("out_height", rsp_tdata[31:16], want.height);
               if (rsp_tdata[79:32] !== want.xshift)
                  report_mismatch("new_xcoef_c", rsp_tdata[79:32], want.xshift);
               if (rsp_tdata[127:80] !== want.yshift)
                  report_mismatch("new_ycoef_c", rsp_tdata[127:80], want.yshift);
               if (rsp_tuser[0] !== want.fault)
                  report_mismatch("fault", rsp_tuser[0], want.fault);
            end
         end
      end
   end

endmodule

### tb/sv/homography_bounding_box_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_bounding_box_tb
// Drives directed and random transforms into the bounding box block under
// several idle and stall patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module homography_bounding_box_tb import hbb_pkg::*;;

   localparam longint ONE_Q = 64'sd4294967296;
   localparam int     CYCLE_LIMIT = 400000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [463:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   int error_count, boxes_pending, boxes_checked, faults_seen;
   int send_idle_pct, recv_stall_pct;
   int hold_cycles;
   int cycle_count;
   int items_sent;

   homography_bounding_box dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   homography_bounding_box_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .error_count(error_count), .boxes_pending(boxes_pending),
      .boxes_checked(boxes_checked), .faults_seen(faults_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // End the run if it hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Response side: stall at random, or hold off for a counted stretch.
   initial begin
      rsp_tready = 1'b0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [47:0] q16(longint v);
      return v[47:0];
   endfunction

   function automatic longint signed_range(longint mag);
      longint v;
      v = {$urandom, $urandom} % (2 * mag + 1);
      return (v < 0 ? -v : v) - mag;
   endfunction

   function automatic logic [463:0] pack_request(int w, int h, logic [47:0] cf[9]);
      logic [463:0] d;
      d = '0;
      d[13:0]  = w[13:0];
      d[27:14] = h[13:0];
      for (int i = 0; i < NCOEF; i++) d[28 + 48 * i +: 48] = cf[i];
      return d;
   endfunction

   // Mostly plausible transforms near identity, some raw noise.
   function automatic logic [463:0] random_request();
      logic [47:0] cf[9];
      int          w, h, sel;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         w = $urandom_range(0, 16383);
         h = $urandom_range(0, 16383);
      end else if (sel < 20) begin
         w = $urandom_range(1, MAX_DIM);
         h = $urandom_range(1, MAX_DIM);
      end else begin
         w = $urandom_range(1, 64);
         h = $urandom_range(1, 64);
      end
      if ($urandom_range(0, 99) < 25) begin
         for (int i = 0; i < NCOEF; i++) cf[i] = 48'({$urandom, $urandom});
      end else begin
         cf[C_XX] = q16(signed_range(2 * ONE_Q));
         cf[C_XY] = q16(signed_range(ONE_Q / 2));
         cf[C_XC] = q16(signed_range(longint'(1) << 42));
         cf[C_YX] = q16(signed_range(ONE_Q / 2));
         cf[C_YY] = q16(signed_range(2 * ONE_Q));
         cf[C_YC] = q16(signed_range(longint'(1) << 42));
         cf[C_WX] = q16(signed_range(longint'(1) << $urandom_range(4, 24)));
         cf[C_WY] = q16(signed_range(longint'(1) << $urandom_range(4, 24)));
         cf[C_WC] = q16(ONE_Q + signed_range(ONE_Q / 4));
         if ($urandom_range(0, 19) == 0) begin
            cf[C_WX] = '0;
            cf[C_WY] = '0;
            cf[C_WC] = '0;
         end
      end
      return pack_request(w, h, cf);
   endfunction

   // Offer one item, with random idle cycles before it.
   task automatic send_item(logic [463:0] d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = d;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (boxes_pending != 0) @(negedge clock);
   endtask

   task automatic send_directed(int w, int h, longint xx, longint xy, longint xc,
                                longint yx, longint yy, longint yc,
                                longint wx, longint wy, longint wc);
      logic [47:0] cf[9];
      cf = '{q16(xx), q16(xy), q16(xc), q16(yx), q16(yy), q16(yc),
             q16(wx), q16(wy), q16(wc)};
      send_item(pack_request(w, h, cf));
   endtask

   initial begin
      longint smax, smin;
      smax = (longint'(1) <<< 47) - 1;
      smin = -smax - 1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      items_sent = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // identity at size extremes, including out-of-range sizes
      send_directed(1, 1, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q);
      send_directed(8192, 8192, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q);
      send_directed(0, 0, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q);
      send_directed(16383, 8193, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q);
      // half-pixel rounding, positive and negative
      send_directed(8, 8, ONE_Q / 2, 0, 0, 0, -ONE_Q / 2, 0, 0, 0, ONE_Q);
      send_directed(7, 5, ONE_Q / 2, ONE_Q / 2, ONE_Q / 2, 0, 0, -ONE_Q / 2, 0, 0, ONE_Q);
      // zero divisor everywhere, and a near-zero divisor at two corners
      send_directed(10, 10, ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, 0);
      send_directed(10, 10, 0, 0, -1, 0, 0, 0, -ONE_Q / 9, 0, ONE_Q);
      // negative divisor mirrors the image
      send_directed(100, 50, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q);
      // size saturation
      send_directed(8192, 8192, 16 * ONE_Q, 0, 0, 0, -16 * ONE_Q, 0, 0, 0, ONE_Q);
      // translation coefficients at both extremes
      send_directed(4, 4, -ONE_Q, 0, smax, 0, ONE_Q, smin, 0, 0, ONE_Q);
      send_directed(4, 4, 0, 0, smin, 0, 0, smax, 0, 0, ONE_Q);
      // coefficient extremes
      send_directed(8192, 8192, smax, smin, smax, smin, smax, smin, smax, smin, smax);
      send_directed(8192, 1, smin, smin, smin, smin, smin, smin, smin, smin, smin);
      send_directed(1, 8192, smax, smax, smax, smax, smax, smax, 1, 1, 1);
      send_directed(3, 3, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      // tiny divisor pushes coordinates past the clamp
      send_directed(2, 2, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, 1);
      // perspective
      send_directed(640, 480, ONE_Q, ONE_Q / 8, 1000 * ONE_Q, 0, ONE_Q, -20 * ONE_Q,
                    ONE_Q / 4096, ONE_Q / 8192, ONE_Q);
      drain_results();

      // random phases: hold-off only, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 24 : 0;
         recv_stall_pct = (phase == 2) ? 64 : (phase == 3) ? 24 : 0;
         if (phase == 0) hold_cycles = 300;
         for (int n = 0; n < 450; n++) send_item(random_request());
         drain_results();
         repeat (40) @(negedge clock);
      end

      req_tvalid = 1'b0;
      drain_results();
      repeat (40) @(negedge clock);
      $display("Sent %0d transforms, checked %0d boxes (%0d with fault set)",
               items_sent, boxes_checked, faults_seen);
      $display("Covered size and coefficient extremes, rounding, zero divisors,");
      $display("saturation, and idle, stall and back-pressure patterns.");
      if (error_count == 0 && boxes_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
